>>> rtl/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types, register indexes and the transition step table of the
// quadrature detent decoder.
// ----------------------------------------------------------------------------
package qdd_pkg;

	// configuration register indexes
	localparam logic [0:0] CFG_INVERT_DIRECTION   = 1'd0;
	localparam logic [0:0] CFG_COARSE_GRANULARITY = 1'd1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 1;

	// pin codes of interest
	localparam logic [1:0] PIN_CODE_ZERO  = 2'd0;
	localparam logic [1:0] PIN_CODE_THREE = 2'd3;

	// detent thresholds in the widened count domain
	localparam logic signed [4:0] FINE_STEPS   = 5'sd2;
	localparam logic signed [4:0] COARSE_STEPS = 5'sd4;

	typedef struct packed {
		logic invert_direction;
		logic coarse_granularity;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        prev_pins;
		logic signed [3:0] partial_steps;
		logic              awaiting_detent;
		logic [31:0]       position_count;
		logic [31:0]       last_change_ms;
		logic [31:0]       elapsed_acc;
	} state_t;

	// signed step for a move from the previous to the current pin code
	function automatic logic signed [2:0] step_lookup(input logic [1:0] prev,
			input logic [1:0] cur);
		logic signed [2:0] s;
		case ({prev, cur})
			4'b00_00: s = 3'sd0;
			4'b00_01: s = 3'sd1;
			4'b00_10: s = -3'sd1;
			4'b00_11: s = 3'sd2;
			4'b01_00: s = -3'sd1;
			4'b01_01: s = 3'sd0;
			4'b01_10: s = 3'sd0;
			4'b01_11: s = 3'sd1;
			4'b10_00: s = 3'sd1;
			4'b10_01: s = 3'sd0;
			4'b10_10: s = 3'sd0;
			4'b10_11: s = -3'sd1;
			4'b11_00: s = -3'sd2;
			4'b11_01: s = -3'sd1;
			4'b11_10: s = 3'sd1;
			default:  s = 3'sd0;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/qdd_if.sv
// ----------------------------------------------------------------------------
// qdd_if
// Valid/ready channels of the quadrature detent decoder: pin samples in,
// position reports out.
// ----------------------------------------------------------------------------
interface qdd_sample_if;
	logic        valid;
	logic        ready;
	logic [1:0]  pin_levels;
	logic        enter_held;
	logic [31:0] now_ms;

	modport source (output valid, output pin_levels, output enter_held, output now_ms,
		input ready);
	modport sink (input valid, input pin_levels, input enter_held, input now_ms,
		output ready);
endinterface

interface qdd_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic [31:0]        elapsed_sum_ms;
	logic               moved;

	modport source (output valid, output position, output elapsed_sum_ms, output moved,
		input ready);
	modport sink (input valid, input position, input elapsed_sum_ms, input moved,
		output ready);
endinterface

>>> rtl/qdd_step.sv
// ----------------------------------------------------------------------------
// qdd_step
// Next-state logic for one pin sample: detent sync, table step, partial
// count, position update and elapsed time accumulation.
// ----------------------------------------------------------------------------
module qdd_step (
	input  qdd_pkg::cfg_t   cfg,
	input  qdd_pkg::state_t cur,
	input  logic [1:0]      pin_levels,
	input  logic            enter_held,
	input  logic [31:0]     now_ms,
	output qdd_pkg::state_t nxt,
	output logic            moved
);

	logic signed [2:0] step_raw;
	logic signed [2:0] step;
	logic signed [4:0] thresh;
	logic signed [4:0] count;
	logic              is_detent;

	assign step_raw  = qdd_pkg::step_lookup(cur.prev_pins, pin_levels);
	assign step      = cfg.invert_direction ? -step_raw : step_raw;
	assign thresh    = cfg.coarse_granularity ? qdd_pkg::COARSE_STEPS : qdd_pkg::FINE_STEPS;
	assign is_detent = (pin_levels == qdd_pkg::PIN_CODE_THREE) ||
		(!cfg.coarse_granularity && (pin_levels == qdd_pkg::PIN_CODE_ZERO));

	// sample update
	always_comb begin
		nxt   = cur;
		moved = 1'b0;
		count = 5'(cur.partial_steps) + 5'(step);
		if (pin_levels != cur.prev_pins) begin
			if (cur.awaiting_detent) begin
				// wait for a rest position before counting
				if (is_detent) begin
					nxt.prev_pins       = pin_levels;
					nxt.awaiting_detent = 1'b0;
				end
			end else begin
				if (count >= thresh) begin
					if (!enter_held) begin
						nxt.position_count = cur.position_count + 32'd1;
						moved              = 1'b1;
					end
					count = count - thresh;
				end else if (count <= -thresh) begin
					if (!enter_held) begin
						nxt.position_count = cur.position_count - 32'd1;
						moved              = 1'b1;
					end
					count = count + thresh;
				end
				nxt.partial_steps = count[3:0];
				nxt.prev_pins     = pin_levels;
				// time since the previous position change
				if (moved) begin
					nxt.elapsed_acc    = cur.elapsed_acc + (now_ms - cur.last_change_ms);
					nxt.last_change_ms = now_ms;
				end
			end
		end
	end

endmodule

>>> rtl/quadrature_detent_decoder.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder
// Turns polled encoder pin samples into a detent position and an
// accumulated time between position changes.
// ----------------------------------------------------------------------------
// Every request on the sample channel yields exactly one result carrying the
// position, the elapsed-time sum and a moved flag. A request is registered on
// acceptance and handled, once the result register is free or being read, by a
// single pass of table lookup, 5-bit count compare and two 32-bit adders, writing
// the decoder state and the result register together. Throughput is one request
// per clock while results are taken; a stalled result holds in the result
// register while one more request waits in the input register. Configuration
// writes take effect on the next sample and should be made while no request
// is in flight.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [qdd_pkg::CFG_DATA_W-1:0]     cfg_data,
	qdd_sample_if.sink                         sample,
	qdd_result_if.source                       result
);

	qdd_pkg::cfg_t   cfg_q;
	qdd_pkg::state_t state_q;
	qdd_pkg::state_t state_nxt;

	logic        valid_s1;
	logic [1:0]  pin_levels_s1;
	logic        enter_held_s1;
	logic [31:0] now_ms_s1;

	logic               valid_s2;
	logic signed [31:0] position_s2;
	logic [31:0]        elapsed_sum_ms_s2;
	logic               moved_s2;

	logic moved_nxt;
	logic advance;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qdd_pkg::CFG_INVERT_DIRECTION:   cfg_q.invert_direction   <= cfg_data[0];
				qdd_pkg::CFG_COARSE_GRANULARITY: cfg_q.coarse_granularity <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pin_levels_s1 <= sample.pin_levels;
			enter_held_s1 <= sample.enter_held;
			now_ms_s1     <= sample.now_ms;
		end
	end

	qdd_step u_step (
		.cfg        (cfg_q),
		.cur        (state_q),
		.pin_levels (pin_levels_s1),
		.enter_held (enter_held_s1),
		.now_ms     (now_ms_s1),
		.nxt        (state_nxt),
		.moved      (moved_nxt)
	);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{prev_pins: 2'd0, partial_steps: 4'sd0, awaiting_detent: 1'b1,
				position_count: 32'd0, last_change_ms: 32'd0, elapsed_acc: 32'd0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			position_s2       <= $signed(state_nxt.position_count);
			elapsed_sum_ms_s2 <= state_nxt.elapsed_acc;
			moved_s2          <= moved_nxt;
		end
	end

	assign result.valid          = valid_s2;
	assign result.position       = position_s2;
	assign result.elapsed_sum_ms = elapsed_sum_ms_s2;
	assign result.moved          = moved_s2;

endmodule

>>> tb/quadrature_detent_decoder_tb.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_tb
// Self-checking bench for the detent decoder. A short table walks the
// detent search, partial counts in both granularities, enter suppression,
// direction inversion and timestamp wrap. Random quadrature walks with noise
// then run under every register setting. Each result is compared against the
// typed values of a checked table row, else against a behavioral copy of the decoder.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 8;
	localparam int MOVES_PER_PHASE = 88;
	localparam int SHOWN_ERRORS  = 10;

	// step per {previous, current} pin code, entry 15 first
	// +1 = 001, -1 = 111, +2 = 010, -2 = 110
	localparam logic [15:0][2:0] STEP_BY_MOVE = {
		3'b000, 3'b001, 3'b111, 3'b110,   // from 3: to 3, 2, 1, 0
		3'b111, 3'b000, 3'b000, 3'b001,   // from 2
		3'b001, 3'b000, 3'b000, 3'b111,   // from 1
		3'b010, 3'b111, 3'b001, 3'b000    // from 0
	};

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_SET_INVERT,
		ROW_SET_COARSE
	} row_kind_e;

	typedef struct packed {
		logic signed [31:0] position;
		logic [31:0]        elapsed_sum_ms;
		logic               moved;
	} report_t;

	typedef struct packed {
		row_kind_e   kind;
		logic [1:0]  pins;       // register value on write rows
		logic        enter;
		logic [31:0] stamp;
		logic        checked;
		report_t     typed;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [qdd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [qdd_pkg::CFG_DATA_W-1:0]  cfg_data;

	qdd_sample_if sample_ch();
	qdd_result_if result_ch();

	quadrature_detent_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// decoder copy: configuration and state
	logic               invert_cfg;
	logic               coarse_cfg;
	logic [1:0]         last_pins;
	logic signed [3:0]  partial_count;
	logic               seek_detent;
	logic signed [31:0] detent_pos;
	logic [31:0]        last_move_ms;
	logic [31:0]        elapsed_total;

	report_t    pending_reports[$];
	table_row_t directed_rows[$];
	int         mismatches;
	int         burst_left;
	logic       sender_steady;
	int         cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run length guard
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports pending", cycles,
				pending_reports.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one poll tick of the decoder, updating the copied state
	function automatic report_t decode_tick(input logic [1:0] pins, input logic enter,
			input logic [31:0] stamp);
		report_t rep;
		int      limit;
		int      step;
		int      count;
		rep.moved = 1'b0;
		if (pins != last_pins) begin
			if (seek_detent) begin
				// only a detent code ends the search
				if (pins == qdd_pkg::PIN_CODE_THREE
						|| (!coarse_cfg && pins == qdd_pkg::PIN_CODE_ZERO)) begin
					last_pins   = pins;
					seek_detent = 1'b0;
				end
			end else begin
				limit = coarse_cfg ? 4 : 2;
				step  = int'($signed(STEP_BY_MOVE[{last_pins, pins}]));
				if (invert_cfg)
					step = -step;
				count = int'(partial_count) + step;
				if (count >= limit) begin
					if (!enter) begin
						detent_pos = detent_pos + 32'sd1;
						rep.moved  = 1'b1;
					end
					count = count - limit;
				end else if (count <= -limit) begin
					if (!enter) begin
						detent_pos = detent_pos - 32'sd1;
						rep.moved  = 1'b1;
					end
					count = count + limit;
				end
				partial_count = 4'(count);
				last_pins     = pins;
				if (rep.moved) begin
					elapsed_total = elapsed_total + (stamp - last_move_ms);
					last_move_ms  = stamp;
				end
			end
		end
		rep.position       = detent_pos;
		rep.elapsed_sum_ms = elapsed_total;
		return rep;
	endfunction

	function automatic table_row_t table_row(input row_kind_e kind, input logic [1:0] pins,
			input logic enter, input logic [31:0] stamp, input logic checked,
			input logic signed [31:0] position, input logic [31:0] elapsed, input logic moved);
		table_row_t r;
		r.kind                 = kind;
		r.pins                 = pins;
		r.enter                = enter;
		r.stamp                = stamp;
		r.checked              = checked;
		r.typed.position       = position;
		r.typed.elapsed_sum_ms = elapsed;
		r.typed.moved          = moved;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input report_t want, input report_t got);
		if (mismatches < SHOWN_ERRORS)
			$display("%s: expected pos %0d sum %0d moved %0b, got pos %0d sum %0d moved %0b",
				what, want.position, want.elapsed_sum_ms, want.moved,
				got.position, got.elapsed_sum_ms, got.moved);
		mismatches++;
	endtask

	// one request on the sample channel, with bursts and gaps
	task automatic send_sample(input logic [1:0] pins, input logic enter,
			input logic [31:0] stamp, input logic checked, input report_t typed);
		report_t predicted;
		int      gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				sample_ch.valid <= 1'b0;
			end
			burst_left = sender_steady ? 1000000 : $urandom_range(1, 16);
		end
		@(negedge clk);
		sample_ch.valid      <= 1'b1;
		sample_ch.pin_levels <= pins;
		sample_ch.enter_held <= enter;
		sample_ch.now_ms     <= stamp;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predicted = decode_tick(pins, enter, stamp);
		pending_reports.push_back(checked ? typed : predicted);
		burst_left--;
	endtask

	// stop sending and wait for every report to come back
	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [qdd_pkg::CFG_INDEX_W-1:0] index, input logic value);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == qdd_pkg::CFG_INVERT_DIRECTION)
			invert_cfg = value;
		else
			coarse_cfg = value;
	endtask

	// result receiver: stall pattern reloaded each time the slot counter wraps
	initial begin
		logic [7:0] stall_bits;
		logic [2:0] slot;
		result_ch.ready = 1'b0;
		stall_bits = 8'hFF;
		slot = 3'd0;
		forever begin
			@(negedge clk);
			if (slot == 3'd0) begin
				if ($urandom_range(0, 3) == 0)
					stall_bits = 8'hFF;
				else
					stall_bits = 8'($urandom) | (8'd1 << $urandom_range(0, 7));
			end
			result_ch.ready <= stall_bits[slot];
			slot = slot + 3'd1;
		end
	end

	// report checker
	always @(posedge clk) begin
		report_t want;
		report_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.position       = result_ch.position;
			got.elapsed_sum_ms = result_ch.elapsed_sum_ms;
			got.moved          = result_ch.moved;
			if (pending_reports.size() == 0) begin
				want = '0;
				note_mismatch("report with no request pending", want, got);
			end else begin
				want = pending_reports.pop_front();
				if (got.position !== want.position
						|| got.elapsed_sum_ms !== want.elapsed_sum_ms
						|| got.moved !== want.moved)
					note_mismatch("report mismatch", want, got);
			end
		end
	end

	// stimulus
	initial begin
		table_row_t r;
		logic [1:0] walk_idx;
		logic [1:0] spin;
		logic [1:0] pins;
		logic [1:0] sent_pins;
		logic       enter;
		logic [31:0] stamp;
		int         moves;
		int         roll;
		report_t    none;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.pin_levels = 2'd0;
		sample_ch.enter_held = 1'b0;
		sample_ch.now_ms     = 32'd0;
		mismatches           = 0;
		burst_left           = 0;
		sender_steady        = 1'b0;
		none                 = '0;

		invert_cfg    = 1'b0;
		coarse_cfg    = 1'b0;
		last_pins     = 2'd0;
		partial_count = 4'sd0;
		seek_detent   = 1'b1;
		detent_pos    = 32'sd0;
		last_move_ms  = 32'd0;
		elapsed_total = 32'd0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// detent search in coarse mode: off-detent codes and code 0 are ignored
		directed_rows.push_back(table_row(ROW_SET_COARSE, 2'd1, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd1, 1'b0, 32'd3, 1'b1, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd2, 1'b0, 32'd4, 1'b1, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd0, 1'b0, 32'd5, 1'b1, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd3, 1'b0, 32'd7, 1'b1, 0, 0, 1'b0));
		// four single steps down, first move timed from zero
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd1, 1'b0, 32'd10, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd0, 1'b0, 32'd20, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd2, 1'b0, 32'd30, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd3, 1'b0, 32'd40, 1'b1, -1, 40, 1'b1));
		// fine mode, double steps, enter held, timestamp extremes
		directed_rows.push_back(table_row(ROW_SET_COARSE, 2'd0, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd2, 1'b0, 32'd50, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd0, 1'b0, 32'd100, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd3, 1'b1, 32'hFFFF_FFFF, 1'b0, 0, 0,
			1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 0, 0,
			1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd0, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0));
		// inverted direction, accumulator wrap, enter held going down
		directed_rows.push_back(table_row(ROW_SET_INVERT, 2'd1, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd3, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd1, 1'b0, 32'd1, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd3, 1'b0, 32'd2, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd2, 1'b1, 32'd3, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd0, 1'b1, 32'd4, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd1, 1'b0, 32'd5, 1'b0, 0, 0, 1'b0));
		// granularity switched with a partial count pending
		directed_rows.push_back(table_row(ROW_SET_COARSE, 2'd1, 1'b0, 32'd0, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd3, 1'b0, 32'd9, 1'b0, 0, 0, 1'b0));
		directed_rows.push_back(table_row(ROW_SAMPLE, 2'd2, 1'b0, 32'd12, 1'b0, 0, 0, 1'b0));

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			case (r.kind)
				ROW_SET_INVERT: begin
					write_reg(qdd_pkg::CFG_INVERT_DIRECTION, r.pins[0]);
				end
				ROW_SET_COARSE: begin
					write_reg(qdd_pkg::CFG_COARSE_GRANULARITY, r.pins[0]);
				end
				default: begin
					send_sample(r.pins, r.enter, r.stamp, r.checked, r.typed);
				end
			endcase
		end

		// random quadrature walks under each register setting
		walk_idx  = {last_pins[1], last_pins[1] ^ last_pins[0]};
		spin      = 2'd1;
		sent_pins = last_pins;
		stamp     = 32'd20;
		for (int phase = 0; phase < PHASES; phase++) begin
			write_reg(qdd_pkg::CFG_INVERT_DIRECTION, phase[0]);
			write_reg(qdd_pkg::CFG_COARSE_GRANULARITY, phase[1]);
			sender_steady = ($urandom_range(0, 3) == 0);
			moves = 0;
			while (moves < MOVES_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					// noise: any code at all
					pins     = 2'($urandom_range(0, 3));
					walk_idx = {pins[1], pins[1] ^ pins[0]};
				end else if (roll < 20) begin
					walk_idx = walk_idx;
				end else if (roll < 28) begin
					walk_idx = walk_idx + 2'd2;
				end else begin
					if ($urandom_range(0, 15) == 0)
						spin = -spin;
					walk_idx = walk_idx + spin;
				end
				pins  = walk_idx ^ (walk_idx >> 1);
				enter = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 24) == 0)
					stamp = $urandom;
				else
					stamp = stamp + 32'($urandom_range(0, 40));
				if (pins != sent_pins)
					moves++;
				sent_pins = pins;
				send_sample(pins, enter, stamp, 1'b0, none);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (pending_reports.size() != 0)
			note_mismatch("request with no report", pending_reports[0], none);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
